/* rtl/core/stcf_pkg.sv */
// shared types, constants and sha-256 helper functions for the trailer check framer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package stcf_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_FIN_APPEND,
    CMD_FIN_VERIFY,
    CMD_SHORT
  } cmd_kind_t;

  // one unit of work handed from the front to the back
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  dat;
    logic [2:0]  sh;
    logic [15:0] given;
  } cmd_t;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sha_k(input logic [5:0] i);
    case (i)
      6'd0:  sha_k = 32'h428a2f98;  6'd1:  sha_k = 32'h71374491;
      6'd2:  sha_k = 32'hb5c0fbcf;  6'd3:  sha_k = 32'he9b5dba5;
      6'd4:  sha_k = 32'h3956c25b;  6'd5:  sha_k = 32'h59f111f1;
      6'd6:  sha_k = 32'h923f82a4;  6'd7:  sha_k = 32'hab1c5ed5;
      6'd8:  sha_k = 32'hd807aa98;  6'd9:  sha_k = 32'h12835b01;
      6'd10: sha_k = 32'h243185be;  6'd11: sha_k = 32'h550c7dc3;
      6'd12: sha_k = 32'h72be5d74;  6'd13: sha_k = 32'h80deb1fe;
      6'd14: sha_k = 32'h9bdc06a7;  6'd15: sha_k = 32'hc19bf174;
      6'd16: sha_k = 32'he49b69c1;  6'd17: sha_k = 32'hefbe4786;
      6'd18: sha_k = 32'h0fc19dc6;  6'd19: sha_k = 32'h240ca1cc;
      6'd20: sha_k = 32'h2de92c6f;  6'd21: sha_k = 32'h4a7484aa;
      6'd22: sha_k = 32'h5cb0a9dc;  6'd23: sha_k = 32'h76f988da;
      6'd24: sha_k = 32'h983e5152;  6'd25: sha_k = 32'ha831c66d;
      6'd26: sha_k = 32'hb00327c8;  6'd27: sha_k = 32'hbf597fc7;
      6'd28: sha_k = 32'hc6e00bf3;  6'd29: sha_k = 32'hd5a79147;
      6'd30: sha_k = 32'h06ca6351;  6'd31: sha_k = 32'h14292967;
      6'd32: sha_k = 32'h27b70a85;  6'd33: sha_k = 32'h2e1b2138;
      6'd34: sha_k = 32'h4d2c6dfc;  6'd35: sha_k = 32'h53380d13;
      6'd36: sha_k = 32'h650a7354;  6'd37: sha_k = 32'h766a0abb;
      6'd38: sha_k = 32'h81c2c92e;  6'd39: sha_k = 32'h92722c85;
      6'd40: sha_k = 32'ha2bfe8a1;  6'd41: sha_k = 32'ha81a664b;
      6'd42: sha_k = 32'hc24b8b70;  6'd43: sha_k = 32'hc76c51a3;
      6'd44: sha_k = 32'hd192e819;  6'd45: sha_k = 32'hd6990624;
      6'd46: sha_k = 32'hf40e3585;  6'd47: sha_k = 32'h106aa070;
      6'd48: sha_k = 32'h19a4c116;  6'd49: sha_k = 32'h1e376c08;
      6'd50: sha_k = 32'h2748774c;  6'd51: sha_k = 32'h34b0bcb5;
      6'd52: sha_k = 32'h391c0cb3;  6'd53: sha_k = 32'h4ed8aa4a;
      6'd54: sha_k = 32'h5b9cca4f;  6'd55: sha_k = 32'h682e6ff3;
      6'd56: sha_k = 32'h748f82ee;  6'd57: sha_k = 32'h78a5636f;
      6'd58: sha_k = 32'h84c87814;  6'd59: sha_k = 32'h8cc70208;
      6'd60: sha_k = 32'h90befffa;  6'd61: sha_k = 32'ha4506ceb;
      6'd62: sha_k = 32'hbef9a3f7;  6'd63: sha_k = 32'hc67178f2;
      default: sha_k = 32'h0;
    endcase
  endfunction

endpackage

`default_nettype wire

/* rtl/core/stcf_front.sv */
// front end: takes input beats, holds the trailing bytes in verify mode, builds commands
// depends on stcf_pkg
`timescale 1ns / 1ps
`default_nettype none

module stcf_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  input  wire logic          cfg_mode,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    data_byte,
  input  wire logic          frame_end,
  input  wire logic [3:0]    final_used_bits,
  input  wire logic          q_full,
  output logic               push,
  output stcf_pkg::cmd_t     push_cmd
);
  import stcf_pkg::*;

  logic       mode;
  logic [7:0] held0;
  logic [7:0] held1;
  logic [1:0] seen;
  logic [2:0] used;
  logic [2:0] sh;
  logic [7:0] mask;
  logic [23:0] trail;
  logic       need;
  logic       fire;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign used     = final_used_bits[2:0];
  assign sh       = 3'(3'd0 - used);
  assign mask     = 8'hff << sh;
  assign trail    = {held0, held1, data_byte};

  always_comb begin
    need           = 1'b1;
    push_cmd.kind  = CMD_DATA;
    push_cmd.dat   = data_byte;
    push_cmd.sh    = sh;
    push_cmd.given = 16'(trail >> sh);
    if (!mode) begin
      if (frame_end) begin
        push_cmd.kind = CMD_FIN_APPEND;
        push_cmd.dat  = data_byte & mask;
      end
    end else if (!frame_end) begin
      // data leaves two beats late
      need         = seen[1];
      push_cmd.dat = held0;
    end else if (!seen[1]) begin
      push_cmd.kind = CMD_SHORT;
      push_cmd.dat  = 8'h00;
    end else begin
      push_cmd.kind = CMD_FIN_VERIFY;
      push_cmd.dat  = held0 & mask;
    end
  end

  assign push = fire && need;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= 1'b0;
      held0 <= 8'h00;
      held1 <= 8'h00;
      seen  <= 2'd0;
    end else if (cfg_valid) begin
      mode  <= cfg_mode;
      held0 <= 8'h00;
      held1 <= 8'h00;
      seen  <= 2'd0;
    end else if (fire) begin
      if (frame_end) begin
        held0 <= 8'h00;
        held1 <= 8'h00;
        seen  <= 2'd0;
      end else begin
        if (mode) begin
          held0 <= held1;
          held1 <= data_byte;
        end
        if (seen != 2'd3) seen <= seen + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stcf_queue.sv */
// short command queue between front and back
// depends on stcf_pkg
`timescale 1ns / 1ps
`default_nettype none

module stcf_queue #(
  parameter int DEPTH = stcf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          clr,
  input  wire logic          push,
  input  wire stcf_pkg::cmd_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               pop_valid,
  output stcf_pkg::cmd_t     pop_data
);
  import stcf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      if (pop)  rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stcf_back.sv */
// back end: sha-256 byte feeder, padding sequencer, round engine and result register
// depends on stcf_pkg
`timescale 1ns / 1ps
`default_nettype none

module stcf_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          clr,
  input  wire logic          cmd_valid,
  input  wire stcf_pkg::cmd_t cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               byte_present,
  output logic               out_last,
  output logic               check_ok
);
  import stcf_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PAD, S_LEN, S_COMP, S_ADD, S_RES} state_t;

  state_t      state;
  state_t      ret_state;
  logic [31:0] hw [8];
  logic [31:0] v  [8];
  logic [31:0] w  [16];
  logic [31:0] w_fed [16];
  logic [31:0] w_rnd [16];
  logic [63:0] len;
  logic [5:0]  pos;
  logic [5:0]  rnd;
  logic [2:0]  lidx;
  logic        pad_first;
  logic [1:0]  res_k;
  cmd_kind_t   c_kind;
  logic [7:0]  c_dat;
  logic [2:0]  c_sh;
  logic [15:0] c_given;

  logic        out_free;
  logic        out_load;
  logic        feed_en;
  logic        feed_data;
  logic [7:0]  feed_byte;
  logic [63:0] bit_len;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;
  logic [23:0] app_word;
  logic [15:0] check;

  assign out_free = !out_valid || out_ready;
  assign cmd_pop  = (state == S_IDLE) && cmd_valid && out_free;
  // a new result beat enters the output register this cycle
  assign out_load = (cmd_pop && (cmd.kind == CMD_DATA || cmd.kind == CMD_SHORT))
                 || ((state == S_RES) && out_free);
  assign bit_len  = {len[60:0], 3'b000};
  assign check    = hw[0][31:16];
  assign app_word = {c_dat, 16'h0000} | (24'(check) << c_sh);

  always_comb begin
    feed_en   = 1'b0;
    feed_data = 1'b0;
    feed_byte = cmd.dat;
    unique case (state)
      S_IDLE: begin
        feed_en   = cmd_pop && (cmd.kind != CMD_SHORT);
        feed_data = feed_en;
      end
      S_PAD: begin
        feed_en   = 1'b1;
        feed_byte = pad_first ? 8'h80 : 8'h00;
      end
      S_LEN: begin
        feed_en   = 1'b1;
        feed_byte = bit_len[{3'd7 - lidx, 3'b000} +: 8];
      end
      default: ;
    endcase
  end

  // byte shift into the 16-word block window, and one schedule step per round
  always_comb begin
    for (int j = 0; j < 15; j++) begin
      w_fed[j] = {w[j][23:0], w[j+1][31:24]};
      w_rnd[j] = w[j+1];
    end
    w_fed[15] = {w[15][23:0], feed_byte};
    w_new = (rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10)) + w[9]
          + (rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3)) + w[0];
    w_rnd[15] = w_new;
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_k(rnd) + w[0];
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      state     <= S_IDLE;
      ret_state <= S_IDLE;
      out_valid <= 1'b0;
      hw        <= SHA_IV;
      len       <= '0;
      pos       <= '0;
      rnd       <= '0;
      lidx      <= '0;
      pad_first <= 1'b0;
      res_k     <= '0;
    end else begin
      if (out_ready && !out_load) out_valid <= 1'b0;
      if (feed_en) begin
        w   <= w_fed;
        pos <= pos + 6'd1;
      end
      if (feed_data) len <= len + 64'd1;

      unique case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            c_kind  <= cmd.kind;
            c_dat   <= cmd.dat;
            c_sh    <= cmd.sh;
            c_given <= cmd.given;
            unique case (cmd.kind)
              CMD_DATA: begin
                out_valid    <= 1'b1;
                out_byte     <= cmd.dat;
                byte_present <= 1'b1;
                out_last     <= 1'b0;
                check_ok     <= 1'b0;
                if (pos == 6'd63) begin
                  state     <= S_COMP;
                  ret_state <= S_IDLE;
                  v         <= hw;
                  rnd       <= '0;
                end
              end
              CMD_FIN_APPEND, CMD_FIN_VERIFY: begin
                pad_first <= 1'b1;
                if (pos == 6'd63) begin
                  state     <= S_COMP;
                  ret_state <= S_PAD;
                  v         <= hw;
                  rnd       <= '0;
                end else begin
                  state <= S_PAD;
                end
              end
              default: begin
                // short frame in verify mode: status only
                out_valid    <= 1'b1;
                out_byte     <= 8'h00;
                byte_present <= 1'b0;
                out_last     <= 1'b1;
                check_ok     <= 1'b0;
                hw           <= SHA_IV;
                len          <= '0;
                pos          <= '0;
              end
            endcase
          end
        end
        S_PAD: begin
          pad_first <= 1'b0;
          if (pos == 6'd55) begin
            state <= S_LEN;
            lidx  <= '0;
          end else if (pos == 6'd63) begin
            state     <= S_COMP;
            ret_state <= S_PAD;
            v         <= hw;
            rnd       <= '0;
          end
        end
        S_LEN: begin
          lidx <= lidx + 3'd1;
          if (lidx == 3'd7) begin
            state     <= S_COMP;
            ret_state <= S_RES;
            v         <= hw;
            rnd       <= '0;
          end
        end
        S_COMP: begin
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          w    <= w_rnd;
          rnd  <= rnd + 6'd1;
          if (rnd == 6'd63) state <= S_ADD;
        end
        S_ADD: begin
          for (int j = 0; j < 8; j++) hw[j] <= hw[j] + v[j];
          res_k <= '0;
          state <= ret_state;
        end
        default: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            byte_present <= 1'b1;
            res_k        <= res_k + 2'd1;
            if (c_kind == CMD_FIN_VERIFY) begin
              out_byte <= c_dat;
              out_last <= 1'b1;
              check_ok <= (check == c_given);
            end else begin
              out_byte <= app_word[{2'd2 - res_k, 3'b000} +: 8];
              out_last <= (res_k == 2'd2);
              check_ok <= 1'b0;
            end
            if (c_kind == CMD_FIN_VERIFY || res_k == 2'd2) begin
              state <= S_IDLE;
              hw    <= SHA_IV;
              len   <= '0;
              pos   <= '0;
            end
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sha256_trailer_check_framer_unit.sv */
// top level of the sha-256 trailer check framer: front, command queue, back
// depends on stcf_pkg, stcf_front, stcf_queue, stcf_back
//
//   channel | signals                                          | dir
//   --------+--------------------------------------------------+-----
//   cfg     | cfg_valid cfg_ready cfg_mode                     | in
//   in      | in_valid in_ready data_byte frame_end final_used_bits | in
//   out     | out_valid out_ready out_byte byte_present out_last check_ok | out
//
// a full 64-byte block runs 64 rounds of the single round unit and the hash add,
// and the back end takes no new command meanwhile
// a frame end feeds padding and length bytes and runs one or two compressions,
// except a short one; result beats: three in append mode, one in verify
// cfg_ready is always high; a mode write restarts the frame; sync reset clears all
// either side may stall: the queue and the result register decouple the two ends
`timescale 1ns / 1ps
`default_nettype none

module sha256_trailer_check_framer_unit #(
  parameter int QUEUE_DEPTH = stcf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_mode,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       frame_end,
  input  wire logic [3:0] final_used_bits,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            byte_present,
  output logic            out_last,
  output logic            check_ok
);
  import stcf_pkg::*;

  logic cfg_wr;
  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic pop_valid;
  cmd_t pop_cmd;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  stcf_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_wr),
    .cfg_mode        (cfg_mode),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .frame_end       (frame_end),
    .final_used_bits (final_used_bits),
    .q_full          (q_full),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  stcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .clr       (cfg_wr),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_data  (pop_cmd)
  );

  stcf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .clr          (cfg_wr),
    .cmd_valid    (pop_valid),
    .cmd          (pop_cmd),
    .cmd_pop      (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .byte_present (byte_present),
    .out_last     (out_last),
    .check_ok     (check_ok)
  );

endmodule

`default_nettype wire

/* bench/stcf_checker.sv */
// checker for the sha-256 trailer check framer: watches cfg, in and out channels,
// predicts each result beat with its own sha-256 model and compares field by field
// depends on nothing but the unit's port signals
`timescale 1ns / 1ps

module stcf_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_mode,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       frame_end,
  input  logic [3:0] final_used_bits,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       byte_present,
  input  logic       out_last,
  input  logic       check_ok,
  output int         fail_count,
  output int         beats_owed
);

  localparam logic MODE_APPEND = 1'b0;

  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [7:0] dat;
    logic       present;
    logic       last;
    logic       ok;
  } out_beat_t;

  out_beat_t   owed_q[$];
  logic [31:0] digest[8];
  logic [7:0]  blk[64];
  logic [63:0] msg_len;
  logic [7:0]  held0, held1;
  logic [1:0]  seen;
  logic        mode;

  assign beats_owed = owed_q.size();

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = digest[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) digest[i] += v[i];
  endfunction

  function automatic void absorb(input logic [7:0] b);
    blk[msg_len[5:0]] = b;
    msg_len++;
    if (msg_len[5:0] == 6'd0) compress();
  endfunction

  // pad, finish and keep the top 16 digest bits
  function automatic logic [15:0] check16();
    int pos;
    logic [63:0] bits;
    pos = int'(msg_len[5:0]);
    bits = msg_len << 3;
    blk[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin blk[pos] = 8'h00; pos++; end
      compress();
      pos = 0;
    end
    while (pos < 56) begin blk[pos] = 8'h00; pos++; end
    for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
    compress();
    return digest[0][31:16];
  endfunction

  function automatic void restart();
    for (int i = 0; i < 8; i++) digest[i] = IV_TAB[i];
    msg_len = '0;
    held0 = '0;
    held1 = '0;
    seen = '0;
  endfunction

  function automatic void owe(input logic [31:0] b, input logic p, input logic l,
                              input logic k);
    out_beat_t r;
    r.dat = b[7:0];
    r.present = p;
    r.last = l;
    r.ok = k;
    owed_q = {owed_q, r};
  endfunction

  function automatic void predict(input logic [7:0] b, input logic fin, input logic [3:0] u);
    logic [31:0] sh, mask, bm, h0, h1, trail, given;
    logic [15:0] c;
    sh = (32'd8 - {29'd0, u[2:0]}) & 32'd7;
    mask = (32'hff << sh) & 32'hff;
    if (mode == MODE_APPEND) begin
      if (!fin) begin
        absorb(b);
        if (seen < 2'd3) seen++;
        owe({24'd0, b}, 1'b1, 1'b0, 1'b0);
        return;
      end
      bm = {24'd0, b} & mask;
      absorb(bm[7:0]);
      c = check16();
      h0 = {24'd0, c[15:8]};
      h1 = {24'd0, c[7:0]};
      owe(bm | (h0 >> (32'd8 - sh)), 1'b1, 1'b0, 1'b0);
      owe(((h0 << sh) & 32'hff) | (h1 >> (32'd8 - sh)), 1'b1, 1'b0, 1'b0);
      owe((h1 << sh) & 32'hff, 1'b1, 1'b1, 1'b0);
      restart();
      return;
    end
    if (!fin) begin
      if (seen >= 2'd2) begin
        absorb(held0);
        owe({24'd0, held0}, 1'b1, 1'b0, 1'b0);
      end
      held0 = held1;
      held1 = b;
      if (seen < 2'd3) seen++;
      return;
    end
    if (seen < 2'd2) begin
      // short frame: status beat only
      owe(32'd0, 1'b0, 1'b1, 1'b0);
      restart();
      return;
    end
    trail = {8'd0, held0, held1, b};
    given = (trail >> sh) & 32'hffff;
    bm = {24'd0, held0} & mask;
    absorb(bm[7:0]);
    c = check16();
    owe(bm, 1'b1, 1'b1, {16'd0, c} == given);
    restart();
  endfunction

  always @(posedge clk) begin
    out_beat_t e;
    if (rst) begin
      mode = MODE_APPEND;
      restart();
      owed_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          $error("result beat with nothing expected: out_byte %0h", out_byte);
          fail_count <= fail_count + 1;
        end else begin
          e = owed_q.pop_front();
          if (out_byte !== e.dat || byte_present !== e.present || out_last !== e.last ||
              check_ok !== e.ok) begin
            fail_count <= fail_count + 1;
            if (out_byte !== e.dat)
              $error("out_byte: expected %0h, got %0h", e.dat, out_byte);
            if (byte_present !== e.present)
              $error("byte_present: expected %0d, got %0d", e.present, byte_present);
            if (out_last !== e.last)
              $error("out_last: expected %0d, got %0d", e.last, out_last);
            if (check_ok !== e.ok)
              $error("check_ok: expected %0d, got %0d", e.ok, check_ok);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        mode = cfg_mode;
        restart();
      end
      if (in_valid && in_ready) predict(data_byte, frame_end, final_used_bits);
    end
  end

endmodule

/* bench/tb.sv */
// top of the trailer check framer bench: clock, reset, stimulus, stalls and verdict
// depends on sha256_trailer_check_framer_unit and stcf_checker
`timescale 1ns / 1ps

module tb;

  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_VERIFY = 1'b1;
  localparam int   IDLE_HOLD = 300;
  localparam int   STALL_LIMIT = 5000;
  localparam int   ITEM_TARGET = 430;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_mode = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = '0;
  logic       frame_end = 1'b0;
  logic [3:0] final_used_bits = 4'd8;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       out_last;
  logic       check_ok;
  int         fail_count;
  int         beats_owed;

  int         items_sent = 0;
  int         quiet_cycles = 0;
  bit         in_burst = 0;
  bit         out_burst = 0;
  int         out_hold = 0;
  bit         out_acc = 0;
  bit         capturing = 0;

  // append-mode output frames, kept for replay in verify mode
  logic [7:0] cap_bytes[$];
  int         cap_len[$];
  logic [3:0] cap_used[$];
  int         cur_len = 0;

  always #4 clk = ~clk;

  sha256_trailer_check_framer_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_mode(cfg_mode),
    .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
    .frame_end(frame_end), .final_used_bits(final_used_bits),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .byte_present(byte_present), .out_last(out_last), .check_ok(check_ok)
  );

  stcf_checker u_chk (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_mode(cfg_mode),
    .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
    .frame_end(frame_end), .final_used_bits(final_used_bits),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .byte_present(byte_present), .out_last(out_last), .check_ok(check_ok),
    .fail_count(fail_count), .beats_owed(beats_owed)
  );

  // capture of accepted result beats
  always @(posedge clk) begin
    out_acc = !rst && out_valid && out_ready;
    if (out_acc && capturing) begin
      cap_bytes = {cap_bytes, out_byte};
      cur_len++;
      if (out_last) begin
        cap_len = {cap_len, cur_len};
        cur_len = 0;
      end
    end
  end

  // receiver stalls, drawn per result beat
  always @(negedge clk) begin
    if (out_acc) begin
      if ($urandom_range(0, 15) == 0) out_burst = ~out_burst;
      out_hold = out_burst ? 0 : $urandom_range(0, 11);
    end
    if (out_hold != 0) begin
      out_ready = 1'b0;
      out_hold--;
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic fin, input logic [3:0] u);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    data_byte = b;
    frame_end = fin;
    final_used_bits = u;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_frame(input logic [7:0] fb[$], input logic [3:0] u);
    in_burst = ($urandom_range(0, 3) == 0);
    if (capturing) cap_used = {cap_used, u};
    foreach (fb[i]) send_beat(fb[i], i == fb.size() - 1, u);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (beats_owed != 0) @(posedge clk);
    repeat (IDLE_HOLD) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    settle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_mode = m;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    capturing = (m == MODE_APPEND);
  endtask

  task automatic random_append_frame();
    logic [7:0] fb[$];
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 130) : $urandom_range(1, 12);
    repeat (n) fb = {fb, 8'($urandom_range(0, 255))};
    send_frame(fb, $urandom_range(0, 15));
  endtask

  // replay one captured frame, sometimes damaged
  task automatic replay_frame();
    logic [7:0] fb[$];
    logic [3:0] u;
    int n, pick;
    n = cap_len.pop_front();
    u = cap_used.pop_front();
    repeat (n) fb = {fb, cap_bytes.pop_front()};
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      n = $urandom_range(0, fb.size() - 1);
      fb[n] = fb[n] ^ (8'd1 << $urandom_range(0, 7));
    end else if (pick == 1) begin
      u = $urandom_range(0, 15);
    end
    send_frame(fb, u);
  endtask

  task automatic random_verify_frame();
    logic [7:0] fb[$];
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 80);
    repeat (n) fb = {fb, 8'($urandom_range(0, 255))};
    send_frame(fb, $urandom_range(0, 15));
  endtask

  initial begin
    logic m;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // append mode from reset: extremes of byte value and used-bit count
    capturing = 1;
    send_frame('{8'hff}, 4'd8);
    send_frame('{8'h00}, 4'd1);
    send_frame('{8'ha5, 8'h5a, 8'h3c}, 4'd0);
    send_frame('{8'hff, 8'hff}, 4'd15);
    send_frame('{8'h80, 8'h01}, 4'd9);
    send_frame('{8'h7f, 8'h00, 8'hff}, 4'd4);

    // verify mode: replayed checks, sometimes damaged, short frames, abandoned frame
    write_mode(MODE_VERIFY);
    replay_frame();
    replay_frame();
    send_frame('{8'hff}, 4'd8);
    send_frame('{8'h00, 8'hff}, 4'd3);
    send_beat(8'h12, 1'b0, 4'd8);
    send_beat(8'h34, 1'b0, 4'd8);
    send_beat(8'h56, 1'b0, 4'd8);
    write_mode(MODE_VERIFY);
    replay_frame();
    replay_frame();
    replay_frame();
    send_frame('{8'hc3, 8'h3c, 8'h99}, 4'd8);

    while (items_sent < ITEM_TARGET) begin
      m = (cap_len.size() == 0) ? MODE_APPEND : MODE_VERIFY;
      if ($urandom_range(0, 3) == 0) m = ~m;
      write_mode(m);
      repeat ($urandom_range(1, 5)) begin
        if (items_sent < ITEM_TARGET) begin
          if (m == MODE_APPEND) random_append_frame();
          else if (cap_len.size() != 0 && $urandom_range(0, 5) != 0) replay_frame();
          else random_verify_frame();
        end
      end
    end

    settle();
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
